// ===== src/ddvp_pkg.sv =====
// Shared types, constants and helper functions of the differential drive
// velocity PID core. No dependencies.
package ddvp_pkg;

  localparam int DATA_W    = 32;
  localparam int DUTY_W    = 10;
  localparam int CFG_N     = 8;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = 68;  // serial multiplier accumulator
  localparam int MUL_STEPS = 32;  // one multiplier bit per cycle
  localparam int QUO_W     = 26;  // scaled duty quotient, at most 699 * 2^16
  localparam int NUM_W     = 59;  // dividend of the limit scaling

  localparam logic signed [16:0] FOLD_BOUND   = 17'sd40000;
  localparam logic [16:0]        COUNT_SPAN   = 17'h10000;
  localparam logic [32:0]        DUTY_LIMIT_Q = 33'd45809664;  // 699.0
  localparam logic [32:0]        DEADZONE_Q   = 33'd655360;    // 10.0
  localparam logic [31:0]        LIN_KP_RESET = 32'd52428800;  // 800.0

  typedef enum logic [3:0] {
    ST_IDLE, ST_MLD, ST_MUL, ST_MPOST, ST_ERR, ST_MIX,
    ST_DIV, ST_DPOST, ST_FIN, ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    CFG_LIN_SCALE, CFG_ANG_SCALE, CFG_LIN_KP, CFG_LIN_KI,
    CFG_LIN_KD, CFG_ANG_KP, CFG_ANG_KI, CFG_ANG_KD
  } cfg_idx_t;

  // sequencer steps, in execution order
  typedef enum logic [3:0] {
    OP_MEAS_LIN, OP_MEAS_ANG, OP_LIN_P, OP_LIN_I, OP_LIN_D,
    OP_ANG_P, OP_ANG_I, OP_ANG_D, OP_LIM_L, OP_DIV_L, OP_LIM_R,
    OP_DIV_R, OP_LIM_UL, OP_DIV_UL, OP_LIM_UA, OP_DIV_UA
  } op_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [67:0] hi;
    logic signed [67:0] lo;
    hi = 68'sd2147483647;
    lo = -68'sd2147483648;
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  function automatic logic [32:0] abs33(input logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction

endpackage

// ===== src/diff_drive_velocity_pid_core.sv =====
// Differential drive velocity controller: wheel count deltas, measured
// speeds, two incremental PID loops, mixing, limiting and duty split.
// Depends on ddvp_pkg.
//
// Usage:
//  - Input channel (in_*): one item per control tick with both 16-bit wheel
//    counter values and the Q16.16 linear and angular commands.
//  - Result channel (out_*): one item per input item with four 10-bit
//    duty compare values, the measured speeds and the limited flag.
//  - Config channel (cfg_*): eight 32-bit gain and scale registers, always
//    ready; write them only while the core is idle.
//  - All products run through one bit-serial shift-add multiplier and all
//    quotients through one restoring divider. A stop command (both
//    setpoints zero) skips the PID loops; when the mixed duties exceed the
//    699 limit, four extra multiply/divide pairs scale the duties and commands.
//  - in_ready is high only while the sequencer is idle.
//  - A finished result sits in the output register; while the receiver
//    stalls the core still takes and works the next item, and waits with
//    that one's result until the register frees up.
//  - Synchronous reset clears the PID history, the last counts and the
//    output valid flag, and loads register defaults.
module diff_drive_velocity_pid_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_left_count,
  input  logic [15:0]        in_right_count,
  input  logic signed [31:0] in_target_linear,
  input  logic signed [31:0] in_target_angular,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [9:0]         out_left_forward_duty,
  output logic [9:0]         out_left_reverse_duty,
  output logic [9:0]         out_right_forward_duty,
  output logic [9:0]         out_right_reverse_duty,
  output logic signed [31:0] out_measured_linear,
  output logic signed [31:0] out_measured_angular,
  output logic               out_limited,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import ddvp_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r;

  logic [DATA_W-1:0] gain_r [CFG_N];

  // per-item operands
  logic [15:0]        last_left_r, last_right_r;
  logic signed [17:0] sum_r, dif_r;
  logic signed [31:0] sp_lin_r, sp_ang_r;
  logic signed [31:0] meas_lin_r, meas_ang_r;
  logic signed [31:0] e_lin_r, e_ang_r;
  logic signed [31:0] u_lin_r, u_ang_r;
  logic signed [32:0] raw_l_r, raw_r_r;
  logic [32:0]        m_r;
  logic               lim_r;
  logic signed [PROD_W-1:0] pid_acc_r;

  // controller history
  logic signed [31:0] lin_e1_r, lin_e2_r, lin_out_r;
  logic signed [31:0] ang_e1_r, ang_e2_r, ang_out_r;

  // serial multiplier
  logic signed [PROD_W-1:0] acc_r, a_sh_r;
  logic [MUL_STEPS-1:0]     b_sh_r;
  logic [4:0]               cnt_r;

  // serial divider
  logic [32:0]      rem_r;
  logic [QUO_W-1:0] nsh_r, q_r;
  logic             neg_r;

  // finished result
  logic [DUTY_W-1:0] res_lf_r, res_lr_r, res_rf_r, res_rr_r;
  logic              res_lim_r;

  logic              out_valid_r;
  logic [DUTY_W-1:0] out_lf_r, out_lr_r, out_rf_r, out_rr_r;
  logic signed [31:0] out_ml_r, out_ma_r;
  logic              out_lim_r;

  logic in_fire, out_load, mul_last, div_last, stop_w, over_w;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign mul_last  = (cnt_r == 5'(MUL_STEPS - 1));
  assign div_last  = (cnt_r == 5'(QUO_W - 1));
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign stop_w    = (sp_lin_r == 32'sd0) && (sp_ang_r == 32'sd0);

  // ---------------- config registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_N; i++) begin
        gain_r[i] <= '0;
      end
      gain_r[CFG_LIN_KP] <= LIN_KP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain_r[cfg_index] <= cfg_data;
    end
  end

  // ---------------- input side: folded count deltas ----------------
  logic signed [16:0] dl_raw, dr_raw, dl_w, dr_w;
  always_comb begin
    dl_raw = 17'({1'b0, in_left_count}) - 17'({1'b0, last_left_r});
    dr_raw = 17'({1'b0, in_right_count}) - 17'({1'b0, last_right_r});
    // fold by one counter span: either direction is the same mod 2^17
    dl_w = (dl_raw > FOLD_BOUND || dl_raw < -FOLD_BOUND) ? dl_raw + COUNT_SPAN : dl_raw;
    dr_w = (dr_raw > FOLD_BOUND || dr_raw < -FOLD_BOUND) ? dr_raw + COUNT_SPAN : dr_raw;
  end

  // ---------------- multiplier operand select ----------------
  logic signed [34:0] d_p_w, d_d_w;
  logic signed [31:0] e_sel, e1_sel, e2_sel;
  logic signed [32:0] x_sel;
  logic [32:0]        x_mag;
  logic signed [PROD_W-1:0] mul_a;
  logic [MUL_STEPS-1:0]     mul_b;

  always_comb begin
    if (op_r == OP_LIN_P || op_r == OP_LIN_I || op_r == OP_LIN_D) begin
      e_sel = e_lin_r; e1_sel = lin_e1_r; e2_sel = lin_e2_r;
    end else begin
      e_sel = e_ang_r; e1_sel = ang_e1_r; e2_sel = ang_e2_r;
    end
    d_p_w = 35'(e_sel) - 35'(e1_sel);
    d_d_w = 35'(e_sel) - (35'(e1_sel) <<< 1) + 35'(e2_sel);
    unique case (op_r)
      OP_LIM_L:  x_sel = raw_l_r;
      OP_LIM_R:  x_sel = raw_r_r;
      OP_LIM_UL: x_sel = 33'(u_lin_r);
      default:   x_sel = 33'(u_ang_r);
    endcase
    x_mag = abs33(x_sel);
    unique case (op_r)
      OP_MEAS_LIN: begin mul_a = PROD_W'(sum_r);  mul_b = gain_r[CFG_LIN_SCALE]; end
      OP_MEAS_ANG: begin mul_a = PROD_W'(dif_r);  mul_b = gain_r[CFG_ANG_SCALE]; end
      OP_LIN_P:    begin mul_a = PROD_W'(d_p_w);  mul_b = gain_r[CFG_LIN_KP]; end
      OP_LIN_I:    begin mul_a = PROD_W'(e_sel);  mul_b = gain_r[CFG_LIN_KI]; end
      OP_LIN_D:    begin mul_a = PROD_W'(d_d_w);  mul_b = gain_r[CFG_LIN_KD]; end
      OP_ANG_P:    begin mul_a = PROD_W'(d_p_w);  mul_b = gain_r[CFG_ANG_KP]; end
      OP_ANG_I:    begin mul_a = PROD_W'(e_sel);  mul_b = gain_r[CFG_ANG_KI]; end
      OP_ANG_D:    begin mul_a = PROD_W'(d_d_w);  mul_b = gain_r[CFG_ANG_KD]; end
      OP_LIM_L, OP_LIM_R, OP_LIM_UL, OP_LIM_UA: begin
        mul_a = PROD_W'({1'b0, x_mag});
        mul_b = DUTY_LIMIT_Q[31:0];
      end
      default:     begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // ---------------- post-processing of a product ----------------
  logic signed [PROD_W-1:0] term_w, meas_w, pid_sum_w;
  logic [NUM_W-1:0]         num_w;
  always_comb begin
    term_w    = (acc_r + PROD_W'(32768)) >>> 16;   // round, ties up
    meas_w    = (acc_r + PROD_W'(128)) >>> 8;
    pid_sum_w = pid_acc_r + term_w;
    num_w     = acc_r[NUM_W-1:0] + NUM_W'(m_r >> 1);
  end

  // ---------------- mixing ----------------
  logic signed [32:0] mix_l_w, mix_r_w;
  logic [32:0]        mag_l_w, mag_r_w, m_w;
  always_comb begin
    mix_l_w = 33'(u_lin_r) - 33'(u_ang_r);
    mix_r_w = 33'(u_lin_r) + 33'(u_ang_r);
    mag_l_w = abs33(mix_l_w);
    mag_r_w = abs33(mix_r_w);
    m_w     = (mag_l_w > mag_r_w) ? mag_l_w : mag_r_w;
    over_w  = (m_w > DUTY_LIMIT_Q);
  end

  // ---------------- divider step ----------------
  logic [33:0] dtry_w;
  logic        dge_w;
  logic signed [32:0] qs_w;
  always_comb begin
    dtry_w = {rem_r, nsh_r[QUO_W-1]};
    dge_w  = (dtry_w >= {1'b0, m_r});
    qs_w   = neg_r ? -33'({7'd0, q_r}) : 33'({7'd0, q_r});
  end

  // ---------------- duty split ----------------
  logic [32:0] dm_l_w, dm_r_w;
  logic        dz_l_w, dz_r_w;
  always_comb begin
    dm_l_w = abs33(raw_l_r);
    dm_r_w = abs33(raw_r_r);
    dz_l_w = (dm_l_w < DEADZONE_Q);
    dz_r_w = (dm_r_w < DEADZONE_Q);
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_MLD;
      ST_MLD:   state_nxt = ST_MUL;
      ST_MUL:   if (mul_last) state_nxt = ST_MPOST;
      ST_MPOST: begin
        priority if (op_r == OP_MEAS_ANG) begin
          state_nxt = ST_ERR;
        end else if (op_r == OP_ANG_D) begin
          state_nxt = ST_MIX;
        end else if (op_r == OP_LIM_L || op_r == OP_LIM_R || op_r == OP_LIM_UL ||
                     op_r == OP_LIM_UA) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_MLD;
        end
      end
      ST_ERR:   state_nxt = stop_w ? ST_DONE : ST_MLD;
      ST_MIX:   state_nxt = over_w ? ST_MLD : ST_FIN;
      ST_DIV:   if (div_last) state_nxt = ST_DPOST;
      ST_DPOST: state_nxt = (op_r == OP_DIV_UA) ? ST_FIN : ST_MLD;
      ST_FIN:   state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r         <= OP_MEAS_LIN;
      last_left_r  <= '0;
      last_right_r <= '0;
      lin_e1_r     <= '0;
      lin_e2_r     <= '0;
      lin_out_r    <= '0;
      ang_e1_r     <= '0;
      ang_e2_r     <= '0;
      ang_out_r    <= '0;
      cnt_r        <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            op_r         <= OP_MEAS_LIN;
            last_left_r  <= in_left_count;
            last_right_r <= in_right_count;
            sum_r        <= 18'(dl_w) + 18'(dr_w);
            dif_r        <= 18'(dr_w) - 18'(dl_w);
            sp_lin_r     <= in_target_linear;
            sp_ang_r     <= (in_target_angular == 32'sh80000000) ? 32'sh7fffffff
                                                                 : -in_target_angular;
          end
        end
        ST_MLD: begin
          acc_r  <= '0;
          a_sh_r <= mul_a;
          b_sh_r <= mul_b;
          neg_r  <= x_sel[32];
          cnt_r  <= '0;
        end
        ST_MUL: begin
          if (b_sh_r[0]) begin
            acc_r <= acc_r + a_sh_r;
          end
          a_sh_r <= a_sh_r <<< 1;
          b_sh_r <= b_sh_r >> 1;
          cnt_r  <= cnt_r + 5'd1;
        end
        ST_MPOST: begin
          op_r <= op_t'(op_r + 4'd1);
          unique case (op_r)
            OP_MEAS_LIN: meas_lin_r <= sat32(meas_w);
            OP_MEAS_ANG: meas_ang_r <= sat32(meas_w);
            OP_LIN_D: begin
              u_lin_r   <= sat32(pid_sum_w);
              pid_acc_r <= PROD_W'(ang_out_r);
            end
            OP_ANG_D:    u_ang_r <= sat32(pid_sum_w);
            OP_LIM_L, OP_LIM_R, OP_LIM_UL, OP_LIM_UA: begin
              rem_r <= num_w[NUM_W-1:QUO_W];
              nsh_r <= num_w[QUO_W-1:0];
              q_r   <= '0;
              cnt_r <= '0;
            end
            default:     pid_acc_r <= pid_sum_w;  // P and I terms
          endcase
        end
        ST_ERR: begin
          e_lin_r   <= sat32(PROD_W'(sp_lin_r) - PROD_W'(meas_lin_r));
          e_ang_r   <= sat32(PROD_W'(sp_ang_r) - PROD_W'(meas_ang_r));
          pid_acc_r <= PROD_W'(lin_out_r);
          if (stop_w) begin
            lin_e1_r  <= '0;
            lin_e2_r  <= '0;
            lin_out_r <= '0;
            ang_e1_r  <= '0;
            ang_e2_r  <= '0;
            ang_out_r <= '0;
            res_lf_r  <= '0;
            res_lr_r  <= '0;
            res_rf_r  <= '0;
            res_rr_r  <= '0;
            res_lim_r <= 1'b0;
          end
        end
        ST_MIX: begin
          raw_l_r <= mix_l_w;
          raw_r_r <= mix_r_w;
          m_r     <= m_w;
          lim_r   <= over_w;
        end
        ST_DIV: begin
          rem_r <= dge_w ? 33'(dtry_w - {1'b0, m_r}) : dtry_w[32:0];
          q_r   <= {q_r[QUO_W-2:0], dge_w};
          nsh_r <= nsh_r << 1;
          cnt_r <= cnt_r + 5'd1;
        end
        ST_DPOST: begin
          op_r <= op_t'(op_r + 4'd1);
          unique case (op_r)
            OP_DIV_L:  raw_l_r <= qs_w;
            OP_DIV_R:  raw_r_r <= qs_w;
            OP_DIV_UL: u_lin_r <= qs_w[31:0];
            default:   u_ang_r <= qs_w[31:0];
          endcase
        end
        ST_FIN: begin
          lin_e2_r  <= lin_e1_r;
          lin_e1_r  <= e_lin_r;
          lin_out_r <= u_lin_r;
          ang_e2_r  <= ang_e1_r;
          ang_e1_r  <= e_ang_r;
          ang_out_r <= u_ang_r;
          res_lf_r  <= (!dz_l_w && !raw_l_r[32]) ? dm_l_w[25:16] : '0;
          res_lr_r  <= (!dz_l_w &&  raw_l_r[32]) ? dm_l_w[25:16] : '0;
          res_rf_r  <= (!dz_r_w && !raw_r_r[32]) ? dm_r_w[25:16] : '0;
          res_rr_r  <= (!dz_r_w &&  raw_r_r[32]) ? dm_r_w[25:16] : '0;
          res_lim_r <= lim_r;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lf_r  <= res_lf_r;
      out_lr_r  <= res_lr_r;
      out_rf_r  <= res_rf_r;
      out_rr_r  <= res_rr_r;
      out_ml_r  <= meas_lin_r;
      out_ma_r  <= meas_ang_r;
      out_lim_r <= res_lim_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_left_forward_duty  = out_lf_r;
  assign out_left_reverse_duty  = out_lr_r;
  assign out_right_forward_duty = out_rf_r;
  assign out_right_reverse_duty = out_rr_r;
  assign out_measured_linear    = out_ml_r;
  assign out_measured_angular   = out_ma_r;
  assign out_limited            = out_lim_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("core took a second item while busy");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_left_forward_duty != 10'd0 && out_left_reverse_duty != 10'd0) &&
                  !(out_right_forward_duty != 10'd0 && out_right_reverse_duty != 10'd0))
    else $error("forward and reverse duty both set");

  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_forward_duty <= 10'd699 && out_left_reverse_duty <= 10'd699 &&
                  out_right_forward_duty <= 10'd699 && out_right_reverse_duty <= 10'd699)
    else $error("duty above limit");
`endif

endmodule
